@@ hw/rtl/binary_max_heap_priority_queue_assert.svh @@
// Assertion macros shared by the heap queue checker.
`ifndef BINARY_MAX_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define BINARY_MAX_HEAP_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define BMHPQ_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define BMHPQ_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/bmhpq_pkg.sv @@
// Types and constants of the binary max-heap priority queue.
package bmhpq_pkg;

  localparam int unsigned REQ_W   = 2;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned TOTAL_W = 7;

  // Request kinds; the fourth code is a no-operation.
  typedef enum logic [REQ_W-1:0] {
    REQ_ENQ  = 2'd0,
    REQ_DEQ  = 2'd1,
    REQ_PEEK = 2'd2
  } req_e;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  // One heap entry: payload and priority.
  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic signed [DATA_W-1:0] prio;
  } entry_t;

endpackage

@@ hw/rtl/bmhpq_req_if.sv @@
// Request channel of the heap queue: valid, ready and the request beat.
interface bmhpq_req_if import bmhpq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic signed [DATA_W-1:0] item_data;
  logic signed [DATA_W-1:0] item_priority;

  modport source (output valid, req_type, item_data, item_priority, input ready);
  modport sink   (input valid, req_type, item_data, item_priority, output ready);
endinterface

@@ hw/rtl/bmhpq_rsp_if.sv @@
// Response channel of the heap queue: valid, ready and the result beat.
interface bmhpq_rsp_if import bmhpq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] out_data;
  logic [STAT_W-1:0]        status;
  logic [TOTAL_W-1:0]       entry_total;

  modport source (output valid, out_data, status, entry_total, input ready);
  modport sink   (input valid, out_data, status, entry_total, output ready);
endinterface

@@ hw/rtl/binary_max_heap_priority_queue.sv @@
// Binary max-heap priority queue held in a synchronous two-read, one-write memory.
//
// The queue takes one request beat at a time and answers each with exactly one
// result beat. Entries live in a memory of HEAP_DEPTH words with registered
// read ports; the entry being moved is kept in a register and only the
// displaced parent or child is written back, so each heap level takes one
// compare of the word read before, one write of an entry and one read of the
// next level. The next request is accepted in the cycle after the result is
// placed in the output register. The output register lets a finished result
// wait for its consumer while the next request is worked on.
// No clearing pass is needed after reset: only entries below the count are read.
module binary_max_heap_priority_queue import bmhpq_pkg::*; #(
  parameter int unsigned HEAP_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bmhpq_req_if.sink   req_i,
  bmhpq_rsp_if.source rsp_o
);

  localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned IW = $clog2(HEAP_DEPTH);
  localparam int unsigned LW = IW + 2;
  localparam logic [CW-1:0] FULL_COUNT = CW'(HEAP_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SU_CMP,
    S_DQ_LOAD,
    S_PK_LOAD,
    S_SD_CMP,
    S_PLACE,
    S_RESP
  } state_e;

  // Heap storage and its registered read ports.
  entry_t heap_mem [HEAP_DEPTH];
  entry_t rd_a_q, rd_b_q;
  logic          rd_en, we;
  logic [IW-1:0] rd_addr_a, rd_addr_b, wr_addr;
  entry_t        wr_data;

  // Control and payload registers.
  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [IW-1:0] hole_q, hole_d;
  logic [IW-1:0] addr_q, addr_d;
  entry_t        item_q, item_d;
  logic signed [DATA_W-1:0] res_data_q, res_data_d;
  status_e       res_status_q, res_status_d;
  logic          out_valid_q, out_valid_d;
  logic signed [DATA_W-1:0] out_data_q, out_data_d;
  status_e       out_status_q, out_status_d;
  logic [TOTAL_W-1:0] out_total_q, out_total_d;

  // Helper values for index arithmetic.
  logic [CW-1:0]      count_m1;
  logic [CW-1:0]      count_par;
  logic [IW-1:0]      addr_par;
  logic [IW:0]        r_idx;
  logic [LW-1:0]      cnt_ext;
  logic               r_ok, take_r;
  logic [IW-1:0]      c_idx;
  entry_t             child;
  logic [IW-1:0]      sd_base;
  logic [LW-1:0]      nl, nr;
  logic               nl_ok, nr_ok;
  logic [CW+TOTAL_W-1:0] total_ext;

  assign count_m1  = count_q - 1'b1;
  assign count_par = count_m1 >> 1;
  assign addr_par  = (addr_q - 1'b1) >> 1;
  assign cnt_ext   = LW'(count_q);
  assign total_ext = {{TOTAL_W{1'b0}}, count_q};

  // Sift-down child choice: the right child wins if it exists and the left is not strictly greater.
  assign r_idx  = {1'b0, addr_q} + 1'b1;
  assign r_ok   = LW'(r_idx) < cnt_ext;
  assign take_r = r_ok && !(rd_a_q.prio > rd_b_q.prio);
  assign c_idx  = take_r ? r_idx[IW-1:0] : addr_q;
  assign child  = take_r ? rd_b_q : rd_a_q;

  // Children of the entry that the hole moves to next.
  assign sd_base = (state_q == S_SD_CMP) ? c_idx : '0;
  assign nl      = {1'b0, sd_base, 1'b1};
  assign nr      = nl + 1'b1;
  assign nl_ok   = nl < cnt_ext;
  assign nr_ok   = nr < cnt_ext;

  // Next-state, memory access and result logic.
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    hole_d       = hole_q;
    addr_d       = addr_q;
    item_d       = item_q;
    res_data_d   = res_data_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_data_d   = out_data_q;
    out_status_d = out_status_q;
    out_total_d  = out_total_q;
    rd_en        = 1'b0;
    rd_addr_a    = '0;
    rd_addr_b    = '0;
    we           = 1'b0;
    wr_addr      = hole_q;
    wr_data      = item_q;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          res_data_d   = '0;
          res_status_d = STAT_OK;
          state_d      = S_RESP;
          unique case (req_i.req_type)
            REQ_ENQ: begin
              if (count_q == FULL_COUNT) begin
                res_status_d = STAT_FULL;
              end else begin
                item_d  = '{data: req_i.item_data, prio: req_i.item_priority};
                hole_d  = count_q[IW-1:0];
                count_d = count_q + 1'b1;
                if (count_q == '0) begin
                  we      = 1'b1;
                  wr_addr = '0;
                  wr_data = '{data: req_i.item_data, prio: req_i.item_priority};
                end else begin
                  rd_en     = 1'b1;
                  rd_addr_a = count_par[IW-1:0];
                  addr_d    = count_par[IW-1:0];
                  state_d   = S_SU_CMP;
                end
              end
            end
            REQ_DEQ: begin
              if (count_q == '0) begin
                res_status_d = STAT_EMPTY;
              end else begin
                rd_en     = 1'b1;
                rd_addr_a = '0;
                rd_addr_b = count_m1[IW-1:0];
                count_d   = count_m1;
                state_d   = S_DQ_LOAD;
              end
            end
            REQ_PEEK: begin
              if (count_q == '0) begin
                res_status_d = STAT_EMPTY;
              end else begin
                rd_en     = 1'b1;
                rd_addr_a = '0;
                state_d   = S_PK_LOAD;
              end
            end
            default: ;
          endcase
        end
      end

      // Compare the new entry with its parent; move the parent down if smaller.
      S_SU_CMP: begin
        we = 1'b1;
        if (item_q.prio > rd_a_q.prio) begin
          wr_data = rd_a_q;
          hole_d  = addr_q;
          if (addr_q == '0) begin
            state_d = S_PLACE;
          end else begin
            rd_en     = 1'b1;
            rd_addr_a = addr_par;
            addr_d    = addr_par;
          end
        end else begin
          state_d = S_RESP;
        end
      end

      S_PK_LOAD: begin
        res_data_d = rd_a_q.data;
        state_d    = S_RESP;
      end

      // Root and last entry are in; the last entry starts its way down from the root.
      S_DQ_LOAD: begin
        res_data_d = rd_a_q.data;
        item_d     = rd_b_q;
        hole_d     = '0;
        state_d    = S_RESP;
        if (count_q != '0) begin
          if (nl_ok) begin
            rd_en     = 1'b1;
            rd_addr_a = nl[IW-1:0];
            rd_addr_b = nr_ok ? nr[IW-1:0] : nl[IW-1:0];
            addr_d    = nl[IW-1:0];
            state_d   = S_SD_CMP;
          end else begin
            we      = 1'b1;
            wr_addr = '0;
            wr_data = rd_b_q;
          end
        end
      end

      // Compare the larger child with the moving entry; move the child up if greater.
      S_SD_CMP: begin
        we = 1'b1;
        if (child.prio > item_q.prio) begin
          wr_data = child;
          hole_d  = c_idx;
          if (nl_ok) begin
            rd_en     = 1'b1;
            rd_addr_a = nl[IW-1:0];
            rd_addr_b = nr_ok ? nr[IW-1:0] : nl[IW-1:0];
            addr_d    = nl[IW-1:0];
          end else begin
            state_d = S_PLACE;
          end
        end else begin
          state_d = S_RESP;
        end
      end

      S_PLACE: begin
        we      = 1'b1;
        state_d = S_RESP;
      end

      // Hand the result to the output register once it is free.
      S_RESP: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_data_d   = res_data_q;
          out_status_d = res_status_q;
          out_total_d  = total_ext[TOTAL_W-1:0];
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // State, count and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    hole_q       <= hole_d;
    addr_q       <= addr_d;
    item_q       <= item_d;
    res_data_q   <= res_data_d;
    res_status_q <= res_status_d;
    out_data_q   <= out_data_d;
    out_status_q <= out_status_d;
    out_total_q  <= out_total_d;
  end

  // Heap memory: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (we) begin
      heap_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_q <= heap_mem[rd_addr_a];
      rd_b_q <= heap_mem[rd_addr_b];
    end
  end

  assign req_i.ready       = (state_q == S_IDLE);
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.out_data    = out_data_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.entry_total = out_total_q;

endmodule

@@ hw/rtl/bmhpq_checker.sv @@
// Port-level assertions for the heap queue and their binding to the top level.
`include "binary_max_heap_priority_queue_assert.svh"

module bmhpq_checker import bmhpq_pkg::*; #(
  parameter int unsigned HEAP_DEPTH = 64
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     rsp_valid_i,
  input logic                     rsp_ready_i,
  input logic signed [DATA_W-1:0] out_data_i,
  input logic [STAT_W-1:0]        status_i,
  input logic [TOTAL_W-1:0]       entry_total_i
);

  localparam logic [TOTAL_W-1:0] FULL_TOTAL = TOTAL_W'(HEAP_DEPTH);

  // A stalled result beat stays valid and unchanged.
  `BMHPQ_ASSERT_NEXT(a_rsp_stall_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(out_data_i) && $stable(status_i) && $stable(entry_total_i), "stalled result beat changed")

  // A dropped enqueue only happens with the heap full and returns no payload.
  `BMHPQ_ASSERT_IMPLY(a_full_total, clk_i, rst_ni, rsp_valid_i && (status_i == STAT_FULL), (entry_total_i == FULL_TOTAL) && (out_data_i == '0), "full status with a heap that is not full")

  // An empty answer leaves the heap empty and returns no payload.
  `BMHPQ_ASSERT_IMPLY(a_empty_total, clk_i, rst_ni, rsp_valid_i && (status_i == STAT_EMPTY), (entry_total_i == '0) && (out_data_i == '0), "empty status with entries held")

endmodule

bind binary_max_heap_priority_queue bmhpq_checker #(
  .HEAP_DEPTH (HEAP_DEPTH)
) u_bmhpq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .out_data_i    (rsp_o.out_data),
  .status_i      (rsp_o.status),
  .entry_total_i (rsp_o.entry_total)
);
